FILE: hdl/htacc_pkg.sv
// Shared types, action codes and helpers for the homogeneous transform accumulator.
// No dependencies; every other file in hdl/ imports this package.
package htacc_pkg;

    localparam int TRIG_FRAC = 16;

    // Action codes carried by the action field of an input beat.
    localparam logic [3:0] ACT_IDENT = 4'd0;
    localparam logic [3:0] ACT_ROTX  = 4'd1;
    localparam logic [3:0] ACT_ROTY  = 4'd2;
    localparam logic [3:0] ACT_ROTZ  = 4'd3;
    localparam logic [3:0] ACT_TRANS = 4'd4;
    localparam logic [3:0] ACT_SCALE = 4'd5;
    localparam logic [3:0] ACT_DH    = 4'd6;
    localparam logic [3:0] ACT_POINT = 4'd7;
    localparam logic [3:0] ACT_ROW   = 4'd8;

    // Fraction alignment applied to one lane product.
    localparam logic [1:0] SH_TRIG = 2'd0;
    localparam logic [1:0] SH_FRAC = 2'd1;
    localparam logic [1:0] SH_DH   = 2'd2;

    typedef logic signed [31:0] t_word;
    typedef logic signed [17:0] t_trig;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [65:0] t_sum;
    typedef t_word t_matrix [16];
    typedef t_word t_vec4 [4];

    typedef struct packed {
        logic [3:0] action;
        t_word      offset_x;
        t_word      offset_y;
        t_word      offset_z;
        t_trig      cos_first;
        t_trig      sin_first;
        t_trig      cos_second;
        t_trig      sin_second;
        t_word      scale_factor;
        logic [1:0] row_select;
    } t_item;

    typedef struct packed {
        logic mat_we;
        logic has_result;
    } t_act_info;

    localparam t_sum SAT_MAX = 66'sh0_7FFF_FFFF;
    localparam t_sum SAT_MIN = -66'sh0_8000_0000;

    function automatic t_word sat32(input t_sum v);
        t_word r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/htacc_lane.sv
// One multiplier lane: a 32x32 signed product followed by a floor shift.
// Depends on htacc_pkg for the word types and shift select codes.
module htacc_lane import htacc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  t_word      i_coef,
    input  t_word      i_opnd,
    input  logic [1:0] i_shift,
    output t_prod      o_term
);

    localparam int DH_SHIFT = 2 * TRIG_FRAC - FRAC_BITS;

    t_prod prod;

    // Both operands are sign-extended words, so the full product fits the 64-bit result.
    assign prod = t_prod'(i_coef) * t_prod'(i_opnd);

    // Arithmetic right shift rounds toward minus infinity.
    always_comb begin
        case (i_shift)
            SH_TRIG: o_term = prod >>> TRIG_FRAC;
            SH_FRAC: o_term = prod >>> FRAC_BITS;
            SH_DH:   o_term = prod >>> DH_SHIFT;
            default: o_term = '0;
        endcase
    end

endmodule

FILE: hdl/htacc_core.sv
// Single-pass datapath: next matrix and result words for one action.
// Depends on htacc_pkg and instantiates 32 htacc_lane multipliers.
module htacc_core import htacc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  t_item     i_item,
    input  t_matrix   i_matrix,
    output t_matrix   o_matrix,
    output t_vec4     o_result,
    output t_act_info o_info
);

    localparam t_word ONE_F = 32'sd1 <<< FRAC_BITS;

    t_word      x, y, z, sc, ct, st, ca, sa, nst, nsa;
    t_word      ofs [4];
    logic [1:0] rot_p, rot_q;
    t_prod      term_a [16];
    t_prod      term_b [16];
    t_word      point [4];
    t_word      row_val [4];

    assign x   = i_item.offset_x;
    assign y   = i_item.offset_y;
    assign z   = i_item.offset_z;
    assign sc  = i_item.scale_factor;
    assign ct  = t_word'(i_item.cos_first);
    assign st  = t_word'(i_item.sin_first);
    assign ca  = t_word'(i_item.cos_second);
    assign sa  = t_word'(i_item.sin_second);
    assign nst = -st;
    assign nsa = -sa;

    assign ofs[0] = x;
    assign ofs[1] = y;
    assign ofs[2] = z;
    assign ofs[3] = '0;

    // Rows mixed by a rotation: x mixes rows 1 and 2, y rows 0 and 2, z rows 0 and 1.
    assign rot_p = (i_item.action == ACT_ROTX) ? 2'd1 : 2'd0;
    assign rot_q = (i_item.action == ACT_ROTZ) ? 2'd1 : 2'd2;

    for (genvar gr = 0; gr < 4; gr++) begin : g_row
        for (genvar gc = 0; gc < 4; gc++) begin : g_col
            localparam int E = gr * 4 + gc;

            t_word      coef_a, opnd_a, coef_b, opnd_b, addend, mp, mq;
            logic [1:0] sh_a, sh_b;

            always_comb begin
                case (i_item.action)
                    ACT_ROTX: begin
                        mp = i_matrix[4 + gc];
                        mq = i_matrix[8 + gc];
                    end
                    ACT_ROTY: begin
                        mp = i_matrix[gc];
                        mq = i_matrix[8 + gc];
                    end
                    default: begin
                        mp = i_matrix[gc];
                        mq = i_matrix[4 + gc];
                    end
                endcase
            end

            always_comb begin
                coef_a = '0;
                opnd_a = '0;
                sh_a   = SH_FRAC;
                coef_b = '0;
                opnd_b = '0;
                sh_b   = SH_TRIG;
                addend = '0;
                case (i_item.action)
                    ACT_IDENT: begin
                        if (gr == gc) begin
                            addend = ONE_F;
                        end
                    end
                    ACT_ROTX, ACT_ROTY, ACT_ROTZ: begin
                        sh_a = SH_TRIG;
                        if (2'(gr) == rot_p) begin
                            coef_a = ct;
                            opnd_a = mp;
                            coef_b = nst;
                            opnd_b = mq;
                        end else if (2'(gr) == rot_q) begin
                            coef_a = st;
                            opnd_a = mp;
                            coef_b = ct;
                            opnd_b = mq;
                        end else begin
                            addend = i_matrix[E];
                        end
                    end
                    ACT_TRANS: begin
                        if (gr < 3) begin
                            coef_a = ofs[gr];
                            opnd_a = i_matrix[12 + gc];
                        end
                        addend = i_matrix[E];
                    end
                    ACT_SCALE: begin
                        if (gr < 3) begin
                            coef_a = sc;
                            opnd_a = i_matrix[E];
                        end else begin
                            addend = i_matrix[E];
                        end
                    end
                    ACT_POINT: begin
                        if (gc < 3) begin
                            coef_a = ofs[gc];
                            opnd_a = i_matrix[E];
                        end
                    end
                    ACT_DH: begin
                        case (E)
                            0: begin
                                coef_a = ct;
                                opnd_a = ONE_F;
                                sh_a   = SH_TRIG;
                            end
                            1: begin
                                coef_a = nst;
                                opnd_a = ONE_F;
                                sh_a   = SH_TRIG;
                            end
                            3: addend = x;
                            4: begin
                                coef_a = st;
                                opnd_a = ca;
                                sh_a   = SH_DH;
                            end
                            5: begin
                                coef_a = ct;
                                opnd_a = ca;
                                sh_a   = SH_DH;
                            end
                            6: begin
                                coef_a = nsa;
                                opnd_a = ONE_F;
                                sh_a   = SH_TRIG;
                            end
                            7: begin
                                coef_a = nsa;
                                opnd_a = z;
                                sh_a   = SH_TRIG;
                            end
                            8: begin
                                coef_a = st;
                                opnd_a = sa;
                                sh_a   = SH_DH;
                            end
                            9: begin
                                coef_a = ct;
                                opnd_a = sa;
                                sh_a   = SH_DH;
                            end
                            10: begin
                                coef_a = ca;
                                opnd_a = ONE_F;
                                sh_a   = SH_TRIG;
                            end
                            11: begin
                                coef_a = ca;
                                opnd_a = z;
                                sh_a   = SH_TRIG;
                            end
                            15: addend = ONE_F;
                            default: addend = '0;
                        endcase
                    end
                    default: begin
                        addend = '0;
                    end
                endcase
            end

            htacc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
                .i_coef  (coef_a),
                .i_opnd  (opnd_a),
                .i_shift (sh_a),
                .o_term  (term_a[E])
            );

            htacc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
                .i_coef  (coef_b),
                .i_opnd  (opnd_b),
                .i_shift (sh_b),
                .o_term  (term_b[E])
            );

            assign o_matrix[E] = sat32(t_sum'(term_a[E]) + t_sum'(term_b[E]) + t_sum'(addend));
        end

        // A point reuses the first three lanes of each row; the fourth column adds in.
        assign point[gr] = sat32(t_sum'(term_a[gr * 4]) + t_sum'(term_a[gr * 4 + 1])
                                 + t_sum'(term_a[gr * 4 + 2]) + t_sum'(i_matrix[gr * 4 + 3]));
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            case (i_item.row_select)
                2'd0:    row_val[k] = i_matrix[k];
                2'd1:    row_val[k] = i_matrix[4 + k];
                2'd2:    row_val[k] = i_matrix[8 + k];
                default: row_val[k] = i_matrix[12 + k];
            endcase
            o_result[k] = (i_item.action == ACT_POINT) ? point[k] : row_val[k];
        end
    end

    assign o_info.mat_we     = (i_item.action <= ACT_DH);
    assign o_info.has_result = (i_item.action == ACT_POINT) || (i_item.action == ACT_ROW);

endmodule

FILE: hdl/homogeneous_transform_accumulator.sv
// An accepted beat is held in the input register until it advances; its result beat,
// if any, is then loaded into the output register and offered until the receiver takes it.
// Throughput: one item per cycle; the matrix update loop closes through one multiplier
// bank (32 lanes of 32x32) and one saturating add back into the matrix register. The
// input stalls only while a result beat waits in the output register and the receiver
// is not ready.
// Reset (synchronous, active low): the matrix becomes the Q.FRAC_BITS identity and
// both the input and output registers are emptied.
module homogeneous_transform_accumulator import htacc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [3:0]   i_action,
    input  t_word        i_offset_x,
    input  t_word        i_offset_y,
    input  t_word        i_offset_z,
    input  t_trig        i_cos_first,
    input  t_trig        i_sin_first,
    input  t_trig        i_cos_second,
    input  t_trig        i_sin_second,
    input  t_word        i_scale_factor,
    input  logic [1:0]   i_row_select,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_word        o_result_x,
    output t_word        o_result_y,
    output t_word        o_result_z,
    output t_word        o_result_w
);

    localparam t_word ONE_F = 32'sd1 <<< FRAC_BITS;

    // Input register: holds one beat while the datapath works on it.
    logic      r_in_valid;
    t_item     r_item;
    t_item     n_item;

    // The transform itself; it is the only state that survives an item.
    t_matrix   r_matrix;
    t_matrix   n_matrix;

    // Output register: parts the result side from the input side.
    logic      r_out_valid;
    t_vec4     r_result;
    t_vec4     n_result;

    t_act_info info;
    logic      advance;

    assign n_item.action       = i_action;
    assign n_item.offset_x     = i_offset_x;
    assign n_item.offset_y     = i_offset_y;
    assign n_item.offset_z     = i_offset_z;
    assign n_item.cos_first    = i_cos_first;
    assign n_item.sin_first    = i_sin_first;
    assign n_item.cos_second   = i_cos_second;
    assign n_item.sin_second   = i_sin_second;
    assign n_item.scale_factor = i_scale_factor;
    assign n_item.row_select   = i_row_select;

    htacc_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .i_item   (r_item),
        .i_matrix (r_matrix),
        .o_matrix (n_matrix),
        .o_result (n_result),
        .o_info   (info)
    );

    // The held item completes this cycle unless it has a result and the output
    // register is full and not being drained.
    assign advance    = r_in_valid && (!info.has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int e = 0; e < 16; e++) begin
                r_matrix[e] <= (e % 5 == 0) ? ONE_F : '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && info.has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Every update of the matrix is a whole-matrix load from the datapath.
            if (advance && info.mat_we) begin
                r_matrix <= n_matrix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
        if (advance && info.has_result) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_x  = r_result[0];
    assign o_result_y  = r_result[1];
    assign o_result_z  = r_result[2];
    assign o_result_w  = r_result[3];

    // A held item that cannot advance must stay put.
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && (r_item == $past(r_item)))
        else $error("input register lost or changed a stalled beat");

    // An item without a result never fills an empty or draining output register.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !info.has_result && !(r_out_valid && !i_out_ready) |=> !r_out_valid)
        else $error("result beat produced by an action without a result");

    // Rotation, translation and scale leave the bottom row untouched.
    a_row3_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.action == ACT_ROTX || r_item.action == ACT_ROTY
                    || r_item.action == ACT_ROTZ || r_item.action == ACT_TRANS
                    || r_item.action == ACT_SCALE)
        |=> r_matrix[12] == $past(r_matrix[12]) && r_matrix[13] == $past(r_matrix[13])
            && r_matrix[14] == $past(r_matrix[14]) && r_matrix[15] == $past(r_matrix[15]))
        else $error("bottom row changed by a premultiply");

    // Identity load puts ones on the diagonal and zeros off it.
    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_item.action == ACT_IDENT
        |=> r_matrix[0] == ONE_F && r_matrix[5] == ONE_F && r_matrix[15] == ONE_F
            && r_matrix[3] == '0 && r_matrix[12] == '0)
        else $error("identity load gave a wrong matrix");

    // A link matrix load ends in the row (0 0 0 1) and has no x-to-z coupling in row 0.
    a_dh_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_item.action == ACT_DH
        |=> r_matrix[2] == '0 && r_matrix[12] == '0 && r_matrix[13] == '0
            && r_matrix[14] == '0 && r_matrix[15] == ONE_F)
        else $error("link matrix load has a wrong fixed pattern");

endmodule

FILE: tb/homogeneous_transform_accumulator_tb.sv
// Self-checking testbench for the homogeneous transform accumulator: directed and random
// action beats on both valid/ready channels, results checked against a behavioral matrix.
// Depends on htacc_pkg and homogeneous_transform_accumulator from hdl/.
module homogeneous_transform_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htacc_pkg::*;

    localparam int FRAC = 16;
    // Number of random beats that actually act on the block (ignored codes excluded).
    localparam int RAND_ITEMS = 750;
    // Time limit in ns, far above the slowest correct run.
    localparam int SIM_LIMIT_NS = 5_000_000;

    // Codes the block leaves alone; they must change nothing and return nothing.
    localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

    localparam t_word WORD_TOP = 32'sh7FFF_FFFF;
    localparam t_word WORD_BOTTOM = 32'sh8000_0000;
    localparam t_word Q_ONE = 32'sh0001_0000;
    localparam t_trig TRIG_ONE = 18'sh10000;
    localparam t_trig TRIG_NEG_ONE = -18'sh10000;
    localparam t_trig TRIG_TOP = 18'sh1FFFF;
    localparam t_trig TRIG_BOTTOM = 18'sh20000;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    // One result beat: four Q16.16 words, x first.
    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        t_word w;
    } t_coord4;

    // Behavioral copy of the matrix plus the queue of result beats it predicts.
    class transform_scoreboard;
        longint mat[16];
        t_coord4 expected_q[$];
        int mismatches;
        int checked;
        int saturations;
        int by_action[16];

        function new();
            unit_matrix(mat, longint'(1) << FRAC);
        endfunction

        function void unit_matrix(output longint m[16], input longint one);
            for (int i = 0; i < 16; i++) begin
                m[i] = (i % 5 == 0) ? one : 0;
            end
        endfunction

        function longint clamp32(longint v);
            if (v > SAT_HI) begin
                saturations++;
                return SAT_HI;
            end
            if (v < SAT_LO) begin
                saturations++;
                return SAT_LO;
            end
            return v;
        endfunction

        // New matrix = a * old, with a carrying s fractional bits. Each product is
        // floored before the exact sum is saturated.
        function void premultiply(longint a[16], int s);
            longint nm[16];
            longint acc;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    acc = 0;
                    for (int k = 0; k < 4; k++) begin
                        acc += (a[r * 4 + k] * mat[k * 4 + c]) >>> s;
                    end
                    nm[r * 4 + c] = clamp32(acc);
                end
            end
            mat = nm;
        endfunction

        function longint dh_single(longint v);
            return clamp32((v * (longint'(1) << FRAC)) >>> TRIG_FRAC);
        endfunction

        function longint dh_pair(longint v1, longint v2);
            return clamp32((v1 * v2 * (longint'(1) << FRAC)) >>> (2 * TRIG_FRAC));
        endfunction

        // Applies one accepted input beat to the matrix and queues its result, if any.
        function void note_input(t_item it);
            longint x, y, z, ct, st, ca, sa, sc, acc;
            longint a[16];
            t_word v[4];
            int base;
            x = longint'($signed(it.offset_x));
            y = longint'($signed(it.offset_y));
            z = longint'($signed(it.offset_z));
            ct = longint'($signed(it.cos_first));
            st = longint'($signed(it.sin_first));
            ca = longint'($signed(it.cos_second));
            sa = longint'($signed(it.sin_second));
            sc = longint'($signed(it.scale_factor));
            by_action[it.action]++;
            case (it.action)
                ACT_IDENT: begin
                    unit_matrix(mat, longint'(1) << FRAC);
                end
                ACT_ROTX: begin
                    unit_matrix(a, longint'(1) << TRIG_FRAC);
                    a[5] = ct; a[6] = -st; a[9] = st; a[10] = ct;
                    premultiply(a, TRIG_FRAC);
                end
                ACT_ROTY: begin
                    // The y rotation keeps the original sign layout: -s above, +s below.
                    unit_matrix(a, longint'(1) << TRIG_FRAC);
                    a[0] = ct; a[2] = -st; a[8] = st; a[10] = ct;
                    premultiply(a, TRIG_FRAC);
                end
                ACT_ROTZ: begin
                    unit_matrix(a, longint'(1) << TRIG_FRAC);
                    a[0] = ct; a[1] = -st; a[4] = st; a[5] = ct;
                    premultiply(a, TRIG_FRAC);
                end
                ACT_TRANS: begin
                    unit_matrix(a, longint'(1) << FRAC);
                    a[3] = x; a[7] = y; a[11] = z;
                    premultiply(a, FRAC);
                end
                ACT_SCALE: begin
                    unit_matrix(a, longint'(1) << FRAC);
                    a[0] = sc; a[5] = sc; a[10] = sc;
                    premultiply(a, FRAC);
                end
                ACT_DH: begin
                    // Negations happen before the floor, so -sin rounds differently from
                    // the negated floor of sin.
                    mat[0] = dh_single(ct);
                    mat[1] = dh_single(-st);
                    mat[2] = 0;
                    mat[3] = x;
                    mat[4] = dh_pair(st, ca);
                    mat[5] = dh_pair(ct, ca);
                    mat[6] = dh_single(-sa);
                    mat[7] = clamp32((-sa * z) >>> TRIG_FRAC);
                    mat[8] = dh_pair(st, sa);
                    mat[9] = dh_pair(ct, sa);
                    mat[10] = dh_single(ca);
                    mat[11] = clamp32((ca * z) >>> TRIG_FRAC);
                    mat[12] = 0;
                    mat[13] = 0;
                    mat[14] = 0;
                    mat[15] = longint'(1) << FRAC;
                end
                ACT_POINT: begin
                    for (int i = 0; i < 4; i++) begin
                        base = i * 4;
                        acc = ((mat[base] * x) >>> FRAC) + ((mat[base + 1] * y) >>> FRAC)
                            + ((mat[base + 2] * z) >>> FRAC) + mat[base + 3];
                        v[i] = t_word'(clamp32(acc));
                    end
                    expected_q.push_back({v[0], v[1], v[2], v[3]});
                end
                ACT_ROW: begin
                    base = int'(it.row_select) * 4;
                    for (int i = 0; i < 4; i++) begin
                        v[i] = t_word'(mat[base + i]);
                    end
                    expected_q.push_back({v[0], v[1], v[2], v[3]});
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_result(t_coord4 got);
            t_coord4 want;
            t_word g[4];
            t_word e[4];
            string lane[4] = '{"x", "y", "z", "w"};
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat %h arrived with none expected", got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            g = '{got.x, got.y, got.z, got.w};
            e = '{want.x, want.y, want.z, want.w};
            for (int i = 0; i < 4; i++) begin
                if (g[i] !== e[i]) begin
                    report_mismatch($sformatf("result %0d lane %s: got %0d, expected %0d",
                                              checked, lane[i], g[i], e[i]));
                end
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic [3:0] i_action = '0;
    t_word i_offset_x = '0;
    t_word i_offset_y = '0;
    t_word i_offset_z = '0;
    t_trig i_cos_first = '0;
    t_trig i_sin_first = '0;
    t_trig i_cos_second = '0;
    t_trig i_sin_second = '0;
    t_word i_scale_factor = '0;
    logic [1:0] i_row_select = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_word o_result_x;
    t_word o_result_y;
    t_word o_result_z;
    t_word o_result_w;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit steady = 1'b0;
    int live_items = 0;

    transform_scoreboard sb = new();

    homogeneous_transform_accumulator #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_offset_x(i_offset_x),
        .i_offset_y(i_offset_y),
        .i_offset_z(i_offset_z),
        .i_cos_first(i_cos_first),
        .i_sin_first(i_sin_first),
        .i_cos_second(i_cos_second),
        .i_sin_second(i_sin_second),
        .i_scale_factor(i_scale_factor),
        .i_row_select(i_row_select),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_result_x(o_result_x),
        .o_result_y(o_result_y),
        .o_result_z(o_result_z),
        .o_result_w(o_result_w)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls about one cycle in four, except during the steady stretch.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 24);
    end

    // Result beats are sampled at the edge where valid and ready are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_result_x, o_result_y, o_result_z, o_result_w});
        end
    end

    function automatic t_item cmd(logic [3:0] act, t_word x = '0, t_word y = '0,
                                  t_word z = '0, t_word sc = '0, t_trig c1 = '0,
                                  t_trig s1 = '0, t_trig c2 = '0, t_trig s2 = '0,
                                  logic [1:0] row = '0);
        t_item it;
        it.action = act;
        it.offset_x = x;
        it.offset_y = y;
        it.offset_z = z;
        it.scale_factor = sc;
        it.cos_first = c1;
        it.sin_first = s1;
        it.cos_second = c2;
        it.sin_second = s2;
        it.row_select = row;
        return it;
    endfunction

    function automatic t_item read_row(logic [1:0] row);
        return cmd(ACT_ROW, '0, '0, '0, '0, '0, '0, '0, '0, row);
    endfunction

    // A coordinate or offset within +-128.0, so chained transforms rarely saturate.
    function automatic t_word moderate();
        return t_word'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endfunction

    // A cosine/sine pair on the unit circle with random quadrant.
    task automatic unit_pair(output t_trig c, output t_trig s);
        int cm;
        int sm;
        cm = $urandom_range(0, 65536);
        sm = $rtoi($sqrt(4294967296.0 - real'(cm) * real'(cm)));
        c = $urandom_range(0, 1) ? t_trig'(-cm) : t_trig'(cm);
        s = $urandom_range(0, 1) ? t_trig'(-sm) : t_trig'(sm);
    endtask

    // Offers one beat, holds it until accepted, records it, then maybe idles a little.
    task automatic send_item(input t_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_action <= it.action;
        i_offset_x <= it.offset_x;
        i_offset_y <= it.offset_y;
        i_offset_z <= it.offset_z;
        i_cos_first <= it.cos_first;
        i_sin_first <= it.sin_first;
        i_cos_second <= it.cos_second;
        i_sin_second <= it.sin_second;
        i_scale_factor <= it.scale_factor;
        i_row_select <= it.row_select;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        if (it.action <= ACT_ROW) live_items++;
        // A random idle gap after about one beat in six gives close to a quarter
        // of idle input cycles.
        if (!steady && $urandom_range(0, 99) < 16) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the input channel until every predicted result beat has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Field extremes, every action, out-of-range trig, saturation and ignored codes.
    task automatic directed_checks();
        for (int r = 0; r < 4; r++) begin
            send_item(read_row(r[1:0]));
        end
        send_item(cmd(ACT_POINT, WORD_BOTTOM, WORD_TOP, -32'sd1));
        // Trig values beyond one are used as given, not clamped.
        send_item(cmd(ACT_ROTX, '0, '0, '0, '0, TRIG_BOTTOM, TRIG_TOP));
        send_item(cmd(ACT_ROTY, '0, '0, '0, '0, '0, TRIG_ONE));
        send_item(cmd(ACT_ROTZ, '0, '0, '0, '0, TRIG_NEG_ONE, TRIG_BOTTOM));
        send_item(read_row(2'd1));
        // Huge translation and most negative scale drive the sums into saturation.
        send_item(cmd(ACT_TRANS, WORD_TOP, WORD_BOTTOM, WORD_TOP));
        send_item(cmd(ACT_SCALE, '0, '0, '0, WORD_BOTTOM));
        send_item(cmd(ACT_POINT, WORD_TOP, WORD_TOP, WORD_BOTTOM));
        send_item(read_row(2'd3));
        send_item(cmd(ACT_UNUSED_LO, t_word'($urandom), t_word'($urandom), t_word'($urandom),
                      t_word'($urandom), TRIG_TOP, TRIG_BOTTOM, TRIG_TOP, TRIG_BOTTOM, 2'd3));
        send_item(cmd(ACT_UNUSED_HI, WORD_BOTTOM, WORD_TOP, WORD_BOTTOM, WORD_TOP));
        send_item(cmd(ACT_DH, WORD_TOP, '0, WORD_BOTTOM, '0, TRIG_BOTTOM, TRIG_BOTTOM,
                      TRIG_BOTTOM, TRIG_TOP));
        send_item(read_row(2'd0));
        send_item(read_row(2'd1));
        send_item(read_row(2'd2));
        send_item(cmd(ACT_POINT, Q_ONE, Q_ONE, Q_ONE));
        send_item(cmd(ACT_IDENT));
        send_item(cmd(ACT_SCALE, '0, '0, '0, '0));
        send_item(read_row(2'd2));
        send_item(cmd(ACT_IDENT));
        // Negative products must floor toward minus infinity.
        send_item(cmd(ACT_POINT, -32'sd1, -32'sd1, -32'sd1));
    endtask

    // A kinematic chain: start frame, a few rigid or scaling updates, then some probes.
    task automatic transform_chain();
        t_trig c, s, c2, s2;
        t_word sc;
        // One chain in ten skips the start frame and works on whatever is left.
        if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 1)) begin
                send_item(cmd(ACT_IDENT));
            end else begin
                unit_pair(c, s);
                unit_pair(c2, s2);
                send_item(cmd(ACT_DH, moderate(), '0, moderate(), '0, c, s, c2, s2));
            end
        end
        repeat ($urandom_range(1, 6)) begin
            unit_pair(c, s);
            case ($urandom_range(0, 4))
                0: send_item(cmd(ACT_ROTX, '0, '0, '0, '0, c, s));
                1: send_item(cmd(ACT_ROTY, '0, '0, '0, '0, c, s));
                2: send_item(cmd(ACT_ROTZ, '0, '0, '0, '0, c, s));
                3: send_item(cmd(ACT_TRANS, moderate(), moderate(), moderate()));
                default: begin
                    sc = t_word'($urandom_range(32768, 131072));
                    if ($urandom_range(0, 7) == 0) sc = -sc;
                    send_item(cmd(ACT_SCALE, '0, '0, '0, sc));
                end
            endcase
        end
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 2) != 0) begin
                send_item(cmd(ACT_POINT, moderate(), moderate(), moderate()));
            end else begin
                send_item(read_row(2'($urandom)));
            end
        end
    endtask

    // Raw random beats: every bit of every field, any code, including ignored ones.
    task automatic noise_item();
        send_item(cmd(4'($urandom_range(0, 15)), t_word'($urandom), t_word'($urandom),
                      t_word'($urandom), t_word'($urandom), t_trig'($urandom),
                      t_trig'($urandom), t_trig'($urandom), t_trig'($urandom),
                      2'($urandom)));
    endtask

    task automatic random_traffic();
        int start;
        int next_drain;
        start = live_items;
        next_drain = 250;
        while (live_items - start < RAND_ITEMS) begin
            // A long stretch in the middle runs at full rate on both sides.
            steady <= (live_items - start >= 300) && (live_items - start < 450);
            if (live_items - start >= next_drain) begin
                drain();
                next_drain += 250;
            end
            if ($urandom_range(0, 99) < 80) begin
                transform_chain();
            end else begin
                noise_item();
            end
        end
    endtask

    initial begin
        int waited;
        int ignored;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_checks();
        random_traffic();
        i_in_valid <= 1'b0;
        steady <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        // Wait on so that any stray result beat is still caught.
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d result beats never arrived", sb.pending()));
        end
        ignored = 0;
        for (int k = ACT_UNUSED_LO; k <= ACT_UNUSED_HI; k++) ignored += sb.by_action[k];
        $display("Run covered %0d acting beats (%0d points, %0d row reads, %0d DH loads)",
                 live_items, sb.by_action[ACT_POINT], sb.by_action[ACT_ROW],
                 sb.by_action[ACT_DH]);
        $display("and %0d ignored codes; %0d result beats compared; %0d saturating sums seen.",
                 ignored, sb.checked, sb.saturations);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(SIM_LIMIT_NS);
        $display("Simulation limit reached with %0d result beats outstanding.", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/htacc_pkg.sv
hdl/htacc_lane.sv
hdl/htacc_core.sv
hdl/homogeneous_transform_accumulator.sv
tb/homogeneous_transform_accumulator_tb.sv
